// ===== rtl/competitive_lotka_volterra_rk4_unit_assert.svh =====
// Assertion macros shared by the checker of the Lotka-Volterra RK4 unit.
`ifndef COMPETITIVE_LOTKA_VOLTERRA_RK4_UNIT_ASSERT_SVH
`define COMPETITIVE_LOTKA_VOLTERRA_RK4_UNIT_ASSERT_SVH

// Property checked on every clock edge outside of reset.
`define CLV_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define CLV_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/clv_pkg.sv =====
// Types, constants and codes of the Lotka-Volterra RK4 unit.
package clv_pkg;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned H_W      = 31;
   localparam int unsigned CNT_W    = 16;
   localparam int unsigned CSR_IDX_W = 8;
   localparam int unsigned ACC_W    = 35;
   localparam int unsigned MAG_W    = 34;
   localparam int unsigned DIVP_W   = MAG_W + DATA_W - 1;
   localparam int unsigned MAX_STEPS = 20000;

   localparam logic [CNT_W-1:0] STEP_LIMIT = CNT_W'(MAX_STEPS - 1);

   localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

   // Reciprocal of three, scaled by 2^33 and rounded up.
   localparam logic [DATA_W-1:0] RECIP_3 = 32'hAAAA_AAAB;

   // Register reset values.
   localparam logic [DATA_W-1:0] RST_GROWTH_X = 32'd167772160;
   localparam logic [DATA_W-1:0] RST_GROWTH_Y = 32'd100663296;
   localparam logic [DATA_W-1:0] RST_SELF_X   = 32'd33554432;
   localparam logic [DATA_W-1:0] RST_CROSS_XY = 32'd50331648;
   localparam logic [DATA_W-1:0] RST_CROSS_YX = 32'd33554432;
   localparam logic [DATA_W-1:0] RST_SELF_Y   = 32'd100663296;
   localparam logic [H_W-1:0]    RST_STEP     = 31'd8389;
   localparam logic [CNT_W-1:0]  RST_INTERVAL = 16'd100;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_GROWTH_X = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GROWTH_Y = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SELF_X   = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CROSS_XY = 8'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CROSS_YX = 8'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SELF_Y   = 8'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP     = 8'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL = 8'd7;

   // Request kinds.
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_STEP = 1'b1;

   typedef enum logic [1:0] {
      OP_MUL = 2'd0,
      OP_ADD = 2'd1,
      OP_SUB = 2'd2
   } alu_op_type;

   typedef struct packed {
      alu_op_type                 op;
      logic signed [DATA_W-1:0]   a;
      logic signed [DATA_W-1:0]   b;
   } alu_cmd_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]   res;
      logic                       sat;
   } alu_rsp_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_EVAL  = 7'b0000010,
      ST_DINIT = 7'b0000100,
      ST_DIV   = 7'b0001000,
      ST_FINX  = 7'b0010000,
      ST_FINY  = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   // Micro-operation slots of one RK4 stage.
   localparam logic [3:0] UOP_LAST = 4'd13;

endpackage

// ===== rtl/clv_if.sv =====
// Request, response and register-write channel interfaces.
interface clv_req_if;
   import clv_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic signed [DATA_W-1:0]  init_x;
   logic signed [DATA_W-1:0]  init_y;
   logic [CNT_W-1:0]          run_id;
   modport source (output valid, req_type, init_x, init_y, run_id, input ready);
   modport sink (input valid, req_type, init_x, init_y, run_id, output ready);
endinterface

interface clv_rsp_if;
   import clv_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [DATA_W-1:0]  x_value;
   logic signed [DATA_W-1:0]  y_value;
   logic [CNT_W-1:0]          step_count;
   logic [CNT_W-1:0]          frame_number;
   logic [CNT_W-1:0]          out_run_id;
   logic                      saturated;
   modport source (output valid, x_value, y_value, step_count, frame_number,
                   out_run_id, saturated, input ready);
   modport sink (input valid, x_value, y_value, step_count, frame_number,
                 out_run_id, saturated, output ready);
endinterface

interface clv_csr_if;
   import clv_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_IDX_W-1:0]      index;
   logic [DATA_W-1:0]         data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/clv_alu.sv =====
// Shared saturating Q8.24 multiply, add and subtract unit.
module clv_alu (
   input  clv_pkg::alu_cmd_type cmd,
   output clv_pkg::alu_rsp_type rsp
);
   import clv_pkg::*;

   logic signed [2*DATA_W-1:0] prod;
   logic signed [2*DATA_W-25:0] prod_sh;
   logic signed [DATA_W:0]     sum;

   // The dropped fraction bits give rounding toward minus infinity.
   always_comb begin
      prod    = cmd.a * cmd.b;
      prod_sh = prod[2*DATA_W-1:24];
      sum     = '0;
      rsp.res = '0;
      rsp.sat = 1'b0;
      case (cmd.op)
         OP_MUL: begin
            if (prod_sh > 40'(SAT_MAX)) begin
               rsp.res = SAT_MAX;
               rsp.sat = 1'b1;
            end else if (prod_sh < 40'(SAT_MIN)) begin
               rsp.res = SAT_MIN;
               rsp.sat = 1'b1;
            end else begin
               rsp.res = prod_sh[DATA_W-1:0];
            end
         end
         OP_ADD, OP_SUB: begin
            if (cmd.op == OP_ADD) begin
               sum = 33'(cmd.a) + 33'(cmd.b);
            end else begin
               sum = 33'(cmd.a) - 33'(cmd.b);
            end
            if (sum[DATA_W] != sum[DATA_W-1]) begin
               rsp.res = sum[DATA_W] ? SAT_MIN : SAT_MAX;
               rsp.sat = 1'b1;
            end else begin
               rsp.res = sum[DATA_W-1:0];
            end
         end
         default: begin
            rsp.res = '0;
            rsp.sat = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/competitive_lotka_volterra_rk4_unit.sv =====
// A step request keeps the block busy after acceptance: the shared multiply/add unit runs
// 4 stages of 14 operations, followed by the magnitude step, the reciprocal multiplies for the
// divide by six, the final adds and, if it emits a sample, the output state. A load request,
// or a step past the step limit, is done on acceptance; requests are taken only while idle.
// Synchronous active-high reset restores the default registers and clears the sequencer, trajectory,
// counters and result flag. A result stays on the response register until taken; a finished step waits for it.
module competitive_lotka_volterra_rk4_unit (
   input  logic       clock,
   input  logic       reset,
   clv_req_if.sink    req_ch,
   clv_rsp_if.source  rsp_ch,
   clv_csr_if.sink    csr_ch
);
   import clv_pkg::*;

   state_type state_ff, state_in;
   logic [3:0] uop_ff, uop_in;
   logic [1:0] stage_ff, stage_in;
   logic       div_cnt_ff, div_cnt_in;

   logic signed [DATA_W-1:0] growth_x_ff, growth_y_ff, self_x_ff;
   logic signed [DATA_W-1:0] cross_xy_ff, cross_yx_ff, self_y_ff;
   logic [H_W-1:0]           step_size_ff;
   logic [CNT_W-1:0]         interval_ff;

   logic signed [DATA_W-1:0] x_ff, y_ff, xs_ff, ys_ff, p_ff, g_ff, kx_ff, ky_ff;
   logic [CNT_W-1:0]         run_ff, step_cnt_ff, frame_ff, cd_ff, cd_next;
   logic                     sat_ff;
   logic signed [ACC_W-1:0]  accx_ff, accy_ff, addx, addy, absx, absy;
   logic [MAG_W-2:0]         halfx_ff, halfy_ff, div_src;
   logic [DIVP_W-1:0]        div_prod;
   logic [DATA_W-1:0]        quox_ff, quoy_ff;
   logic                     negx_ff, negy_ff;
   logic signed [DATA_W-1:0] qx, qy, hx, hy;

   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_x_ff, rsp_y_ff;
   logic [CNT_W-1:0]         rsp_step_ff, rsp_frame_ff, rsp_run_ff;
   logic                     rsp_sat_ff;

   alu_cmd_type alu_cmd;
   alu_rsp_type alu_rsp;
   logic        req_acc, out_free, alu_use;

   clv_alu u_alu (.cmd(alu_cmd), .rsp(alu_rsp));

   assign req_acc  = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign cd_next  = cd_ff + 16'd1;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.x_value      = rsp_x_ff;
   assign rsp_ch.y_value      = rsp_y_ff;
   assign rsp_ch.step_count   = rsp_step_ff;
   assign rsp_ch.frame_number = rsp_frame_ff;
   assign rsp_ch.out_run_id   = rsp_run_ff;
   assign rsp_ch.saturated    = rsp_sat_ff;

   // Stage increments: halved for the first two stages, whole for the third.
   assign hx = (stage_ff == 2'd2) ? kx_ff : (kx_ff >>> 1);
   assign hy = (stage_ff == 2'd2) ? ky_ff : (ky_ff >>> 1);

   // Weighted stage sums: the middle stages count twice.
   assign addx = (stage_ff == 2'd1 || stage_ff == 2'd2) ?
                 (ACC_W'(kx_ff) <<< 1) : ACC_W'(kx_ff);
   assign addy = (stage_ff == 2'd1 || stage_ff == 2'd2) ?
                 (ACC_W'(ky_ff) <<< 1) : ACC_W'(ky_ff);

   // Magnitudes of the weighted sums.
   assign absx = accx_ff[ACC_W-1] ? -accx_ff : accx_ff;
   assign absy = accy_ff[ACC_W-1] ? -accy_ff : accy_ff;

   // Divide by six as a halving and a multiply by one third; exact for every reachable sum.
   assign div_src  = div_cnt_ff ? halfy_ff : halfx_ff;
   assign div_prod = DIVP_W'(div_src) * DIVP_W'(RECIP_3);

   // Quotients of the divide by six, truncated toward zero.
   assign qx = negx_ff ? -signed'(quox_ff) : signed'(quox_ff);
   assign qy = negy_ff ? -signed'(quoy_ff) : signed'(quoy_ff);

   // Operand selection for the shared unit.
   always_comb begin
      alu_cmd = '{op: OP_MUL, a: '0, b: '0};
      alu_use = 1'b0;
      case (state_ff)
         ST_EVAL: begin
            alu_use = 1'b1;
            case (uop_ff)
               4'd0:  alu_cmd = '{op: OP_MUL, a: self_x_ff, b: xs_ff};
               4'd1:  alu_cmd = '{op: OP_SUB, a: growth_x_ff, b: p_ff};
               4'd2:  alu_cmd = '{op: OP_MUL, a: cross_xy_ff, b: ys_ff};
               4'd3:  alu_cmd = '{op: OP_SUB, a: g_ff, b: p_ff};
               4'd4:  alu_cmd = '{op: OP_MUL, a: g_ff, b: xs_ff};
               4'd5:  alu_cmd = '{op: OP_MUL, a: {1'b0, step_size_ff}, b: p_ff};
               4'd6:  alu_cmd = '{op: OP_MUL, a: cross_yx_ff, b: xs_ff};
               4'd7:  alu_cmd = '{op: OP_SUB, a: growth_y_ff, b: p_ff};
               4'd8:  alu_cmd = '{op: OP_MUL, a: self_y_ff, b: ys_ff};
               4'd9:  alu_cmd = '{op: OP_SUB, a: g_ff, b: p_ff};
               4'd10: alu_cmd = '{op: OP_MUL, a: g_ff, b: ys_ff};
               4'd11: alu_cmd = '{op: OP_MUL, a: {1'b0, step_size_ff}, b: p_ff};
               4'd12: alu_cmd = '{op: OP_ADD, a: x_ff, b: hx};
               4'd13: alu_cmd = '{op: OP_ADD, a: y_ff, b: hy};
               default: alu_use = 1'b0;
            endcase
            // The last stage needs no next evaluation point, so its adds do not count.
            if (stage_ff == 2'd3 && uop_ff >= 4'd12) begin
               alu_use = 1'b0;
            end
         end
         ST_FINX: begin
            alu_use = 1'b1;
            alu_cmd = '{op: OP_ADD, a: x_ff, b: qx};
         end
         ST_FINY: begin
            alu_use = 1'b1;
            alu_cmd = '{op: OP_ADD, a: y_ff, b: qy};
         end
         default: alu_use = 1'b0;
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      uop_in     = uop_ff;
      stage_in   = stage_ff;
      div_cnt_in = div_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            uop_in   = '0;
            stage_in = '0;
            if (req_acc && req_ch.req_type == REQ_STEP && step_cnt_ff < STEP_LIMIT) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (uop_ff == UOP_LAST) begin
               uop_in   = '0;
               stage_in = stage_ff + 2'd1;
               if (stage_ff == 2'd3) begin
                  state_in = ST_DINIT;
               end
            end else begin
               uop_in = uop_ff + 4'd1;
            end
         end
         ST_DINIT: begin
            div_cnt_in = 1'b0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            div_cnt_in = ~div_cnt_ff;
            if (div_cnt_ff) begin
               state_in = ST_FINX;
            end
         end
         ST_FINX: state_in = ST_FINY;
         ST_FINY: state_in = (cd_next >= interval_ff) ? ST_OUT : ST_IDLE;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         uop_ff     <= '0;
         stage_ff   <= '0;
         div_cnt_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         uop_ff     <= uop_in;
         stage_ff   <= stage_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         growth_x_ff  <= RST_GROWTH_X;
         growth_y_ff  <= RST_GROWTH_Y;
         self_x_ff    <= RST_SELF_X;
         cross_xy_ff  <= RST_CROSS_XY;
         cross_yx_ff  <= RST_CROSS_YX;
         self_y_ff    <= RST_SELF_Y;
         step_size_ff <= RST_STEP;
         interval_ff  <= RST_INTERVAL;
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            CSR_GROWTH_X: growth_x_ff  <= csr_ch.data;
            CSR_GROWTH_Y: growth_y_ff  <= csr_ch.data;
            CSR_SELF_X:   self_x_ff    <= csr_ch.data;
            CSR_CROSS_XY: cross_xy_ff  <= csr_ch.data;
            CSR_CROSS_YX: cross_yx_ff  <= csr_ch.data;
            CSR_SELF_Y:   self_y_ff    <= csr_ch.data;
            CSR_STEP:     step_size_ff <= csr_ch.data[H_W-1:0];
            CSR_INTERVAL: interval_ff  <= csr_ch.data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Trajectory state and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff        <= '0;
         y_ff        <= '0;
         run_ff      <= '0;
         step_cnt_ff <= '0;
         frame_ff    <= '0;
         cd_ff       <= '0;
         sat_ff      <= 1'b0;
      end else begin
         if (alu_use && alu_rsp.sat) begin
            sat_ff <= 1'b1;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_acc && req_ch.req_type == REQ_LOAD) begin
                  x_ff        <= req_ch.init_x;
                  y_ff        <= req_ch.init_y;
                  run_ff      <= req_ch.run_id;
                  step_cnt_ff <= '0;
                  frame_ff    <= '0;
                  cd_ff       <= '0;
                  sat_ff      <= 1'b0;
               end
            end
            ST_FINX: x_ff <= alu_rsp.res;
            ST_FINY: begin
               y_ff        <= alu_rsp.res;
               step_cnt_ff <= step_cnt_ff + 16'd1;
               cd_ff       <= cd_next;
            end
            ST_OUT: begin
               if (out_free) begin
                  frame_ff <= frame_ff + 16'd1;
                  cd_ff    <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   // Working registers of one step.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            xs_ff   <= x_ff;
            ys_ff   <= y_ff;
            accx_ff <= '0;
            accy_ff <= '0;
         end
         ST_EVAL: begin
            case (uop_ff)
               4'd0, 4'd2, 4'd4, 4'd6, 4'd8, 4'd10: p_ff <= alu_rsp.res;
               4'd1, 4'd3, 4'd7, 4'd9: g_ff <= alu_rsp.res;
               4'd5:  kx_ff <= alu_rsp.res;
               4'd11: ky_ff <= alu_rsp.res;
               4'd12: begin
                  xs_ff   <= alu_rsp.res;
                  accx_ff <= accx_ff + addx;
               end
               4'd13: begin
                  ys_ff   <= alu_rsp.res;
                  accy_ff <= accy_ff + addy;
               end
               default: ;
            endcase
         end
         ST_DINIT: begin
            negx_ff  <= accx_ff[ACC_W-1];
            negy_ff  <= accy_ff[ACC_W-1];
            halfx_ff <= absx[MAG_W-1:1];
            halfy_ff <= absy[MAG_W-1:1];
         end
         ST_DIV: begin
            if (div_cnt_ff) begin
               quoy_ff <= div_prod[DIVP_W-1:MAG_W-1];
            end else begin
               quox_ff <= div_prod[DIVP_W-1:MAG_W-1];
            end
         end
         default: ;
      endcase
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         rsp_x_ff     <= x_ff;
         rsp_y_ff     <= y_ff;
         rsp_step_ff  <= step_cnt_ff;
         rsp_frame_ff <= frame_ff;
         rsp_run_ff   <= run_ff;
         rsp_sat_ff   <= sat_ff;
      end
   end

endmodule

// ===== rtl/clv_checker.sv =====
// Port-level checker for the Lotka-Volterra RK4 unit, with its bind.
`include "competitive_lotka_volterra_rk4_unit_assert.svh"

module clv_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_type,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [clv_pkg::DATA_W-1:0] rsp_x
);
   import clv_pkg::*;

   // A waiting result is held until it is taken.
   `CLV_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped")
   `CLV_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_x), "response changed")
   // A load finishes at once, so the block is ready again the next cycle.
   `CLV_ASSERT(a_load_fast, req_valid && req_ready && req_type == REQ_LOAD |=> req_ready,
               "load did not return to idle")
   // A new result only comes out of a step that kept the block busy.
   `CLV_ASSERT(a_rsp_from_step, $rose(rsp_valid) |-> $past(!req_ready), "result without work")
   // Reset leaves no result pending.
   `CLV_ASSERT_ALWAYS(a_rst_empty, reset |=> !rsp_valid, "result after reset")

endmodule

bind competitive_lotka_volterra_rk4_unit clv_checker u_clv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .req_type  (req_ch.req_type),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_x     (rsp_ch.x_value)
);
